// ===== hw/rtl/seoc_pkg.sv =====
// Shared types, constants and helper functions for the Sobel edge orientation color block.
package seoc_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  // Reset values and limits of the frame geometry.
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [11:0] HEIGHT_LIMIT = 12'd2048;

  // Grey conversion: floor(sum / 10) equals (sum * 6554) >> 16 for sums up to 2550.
  localparam logic [12:0] GREY_RECIP = 13'd6554;

  // Square root unit: the sum of squares stays below 4^11, so 11 steps suffice.
  localparam int          ROOT_W     = 22;
  localparam logic [ROOT_W-1:0] ROOT_FIRST_BIT = ROOT_W'(1) << 20;

  // Zero-padding flags for the window border: top row, bottom row, left and right column.
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } edge_mask_t;

  // Floor of a quarter, clamped to 0..255.
  function automatic logic [7:0] clamp_quarter(input logic signed [12:0] t);
    logic [7:0] q;
    if (t <= 13'sd0) begin
      q = 8'd0;
    end else if (t[11:10] != 2'b00) begin
      q = 8'hFF;
    end else begin
      q = t[9:2];
    end
    return q;
  endfunction

endpackage

// ===== hw/rtl/seoc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module seoc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sobel_edge_orientation_color.sv =====
// Top level of the Sobel edge detector with orientation coloring of the gradient.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata red,green,blue; tuser action
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata edge r,g,b; tlast frame_end
//  cfg       | in        | cfg_we (always taken)         | cfg_addr index, cfg_data value
//
// An item without a result visits the idle and window states only; one with a result then visits
// sum, square, root and output, mostly the square root unit: one result bit per cycle (11 steps).
// Both line buffers share one RAM word per column, read at acceptance, written back in the window state.
// Reset is synchronous; it clears the counters, the window and the frame geometry, not the RAM.
// A result waits in the output register; a new item is accepted meanwhile, and the block
// stalls only when a second result is ready before the first one has been taken.
module sobel_edge_orientation_color #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // Pixel input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tuser,   // action: 0 real pixel, 1 drain item
  // Edge color output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // edge_red [7:0], edge_green [15:8], edge_blue [23:16]
  output logic        m_axis_tlast,   // frame_end
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [11:0] cfg_data
);

  import seoc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam int WLIM = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam logic [11:0] WIDTH_LIM = 12'(WLIM);
  localparam logic [11:0] WIDTH_INIT = (WIDTH_RESET > WIDTH_LIM) ? WIDTH_LIM : WIDTH_RESET;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_SUM,
    ST_SQ,
    ST_ROOT,
    ST_OUT
  } state_t;

  state_t state;

  // Frame geometry, stored already normalized to its legal range.
  logic [11:0] width_reg;
  logic [11:0] height_reg;

  // Input position counters.
  logic [AW-1:0] col_cnt;
  logic [11:0]   row_cnt;

  // Item held while it is worked on.
  logic          cur_action;
  logic [7:0]    cur_red;
  logic [7:0]    cur_green;
  logic [7:0]    cur_blue;
  logic [AW-1:0] cur_col;
  logic [11:0]   cur_row;
  logic          cur_last;
  logic          cur_emit;
  edge_mask_t    cur_mask;

  // 3x3 grey window, row 0 oldest line, column 2 newest pixel.
  logic [7:0] win [9];

  // Gradient and square root registers.
  logic signed [10:0] sx;
  logic signed [10:0] sy;
  logic [ROOT_W-1:0]  rt_v;
  logic [ROOT_W-1:0]  rt_res;
  logic [ROOT_W-1:0]  rt_bit;

  // Output register.
  logic        out_valid;
  logic [23:0] out_data;
  logic        out_last;

  // Line buffer RAM: upper line in the high byte, middle line in the low byte.
  logic [15:0] lb_rd_data;
  logic [15:0] lb_wr_data;
  logic        accept;

  // Position logic at acceptance.
  logic [CW-1:0] w_ext;
  logic [CW-1:0] c_inc;
  logic [11:0]   h1;
  logic [AW-1:0] c1, c2, col_next;
  logic [11:0]   r1, r2, row_next;
  logic          acc_last;
  logic          acc_emit;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    w_ext = CW'(width_reg);
    h1    = height_reg + 12'd1;
    // A column at or past the width wraps to the next row.
    if (CW'(col_cnt) >= w_ext) begin
      c1 = '0;
      r1 = row_cnt + 12'd1;
    end else begin
      c1 = col_cnt;
      r1 = row_cnt;
    end
    // A position past the last drain item restarts the frame.
    if ((r1 > h1) || ((r1 == h1) && (c1 != '0))) begin
      c2 = '0;
      r2 = '0;
    end else begin
      c2 = c1;
      r2 = r1;
    end
    acc_last = (r2 == h1);
    acc_emit = (r2 >= 12'd2) || ((r2 == 12'd1) && (c2 != '0));
    c_inc    = CW'(c2) + CW'(1);
    if (acc_last) begin
      col_next = '0;
      row_next = '0;
    end else if (c_inc >= w_ext) begin
      col_next = '0;
      row_next = r2 + 12'd1;
    end else begin
      col_next = c_inc[AW-1:0];
      row_next = r2;
    end
  end

  // Grey value of the held pixel; drain items are black.
  logic [11:0] grey_sum;
  logic [24:0] grey_prod;
  logic [7:0]  grey;

  always_comb begin
    grey_sum  = 12'(cur_red) * 12'd3 + 12'(cur_green) * 12'd6 + 12'(cur_blue);
    grey_prod = 25'(grey_sum) * 25'(GREY_RECIP);
    grey      = cur_action ? 8'd0 : grey_prod[23:16];
  end

  assign lb_wr_data = {lb_rd_data[7:0], grey};

  seoc_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (state == ST_WIN),
    .wr_addr (cur_col),
    .wr_data (lb_wr_data),
    .rd_en   (accept),
    .rd_addr (c2),
    .rd_data (lb_rd_data)
  );

  // Border flags of the output pixel, which trails the input by one row and one pixel.
  edge_mask_t mask_next;

  always_comb begin
    if (cur_col == '0) begin
      mask_next.top = (cur_row == 12'd2);
      mask_next.bot = (cur_row == h1);
      mask_next.lft = (width_reg == 12'd1);
      mask_next.rgt = 1'b1;
    end else begin
      mask_next.top = (cur_row == 12'd1);
      mask_next.bot = (cur_row == height_reg);
      mask_next.lft = (cur_col == AW'(1));
      mask_next.rgt = 1'b0;
    end
  end

  // Sobel sums over the zero-padded window.
  logic [7:0]         g [9];
  logic signed [11:0] sx_sum;
  logic signed [11:0] sy_sum;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      g[i] = win[i];
      if ((i < 3 && cur_mask.top) || (i >= 6 && cur_mask.bot) ||
          (i % 3 == 0 && cur_mask.lft) || (i % 3 == 2 && cur_mask.rgt)) begin
        g[i] = 8'd0;
      end
    end
    sx_sum = $signed({4'd0, g[0]}) - $signed({4'd0, g[2]})
           + $signed({3'd0, g[3], 1'b0}) - $signed({3'd0, g[5], 1'b0})
           + $signed({4'd0, g[6]}) - $signed({4'd0, g[8]});
    sy_sum = $signed({4'd0, g[6]}) + $signed({3'd0, g[7], 1'b0}) + $signed({4'd0, g[8]})
           - $signed({4'd0, g[0]}) - $signed({3'd0, g[1], 1'b0}) - $signed({4'd0, g[2]});
  end

  // Sum of squares.
  logic signed [21:0] sx_sq;
  logic signed [21:0] sy_sq;

  assign sx_sq = sx * sx;
  assign sy_sq = sy * sy;

  // One step of the bitwise square root.
  logic [ROOT_W-1:0] rt_trial;

  assign rt_trial = rt_res + rt_bit;

  // Orientation colors from the gradient and its magnitude.
  logic [10:0]        mag;
  logic signed [12:0] t_red;
  logic signed [12:0] t_green;
  logic signed [12:0] t_blue;

  always_comb begin
    mag     = rt_res[10:0];
    t_red   = 13'(sy) + $signed({2'b00, mag});
    t_green = 13'(sx) + $signed({2'b00, mag});
    t_blue  = -(13'(sx) + 13'(sy));
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      width_reg  <= WIDTH_INIT;
      height_reg <= HEIGHT_RESET;
      col_cnt    <= '0;
      row_cnt    <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= 8'd0;
      end
    end else begin
      // Configuration writes, clamped to the legal range.
      if (cfg_we) begin
        case (cfg_index_t'(cfg_addr))
          CFG_IMAGE_WIDTH: begin
            if (cfg_data == 12'd0) begin
              width_reg <= 12'd1;
            end else if (cfg_data > WIDTH_LIM) begin
              width_reg <= WIDTH_LIM;
            end else begin
              width_reg <= cfg_data;
            end
          end
          CFG_IMAGE_HEIGHT: begin
            if (cfg_data == 12'd0) begin
              height_reg <= 12'd1;
            end else if (cfg_data > HEIGHT_LIMIT) begin
              height_reg <= HEIGHT_LIMIT;
            end else begin
              height_reg <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end

      // A taken result frees the output register; in the output state it is reloaded instead.
      if (out_valid && m_axis_tready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_action <= s_axis_tuser;
            cur_red    <= s_axis_tdata[7:0];
            cur_green  <= s_axis_tdata[15:8];
            cur_blue   <= s_axis_tdata[23:16];
            cur_col    <= c2;
            cur_row    <= r2;
            cur_last   <= acc_last;
            cur_emit   <= acc_emit;
            col_cnt    <= col_next;
            row_cnt    <= row_next;
            state      <= ST_WIN;
          end
        end
        ST_WIN: begin
          // Shift the window and bring in the new column.
          for (int r = 0; r < 3; r++) begin
            win[r*3]     <= win[r*3+1];
            win[r*3+1]   <= win[r*3+2];
          end
          win[2]   <= lb_rd_data[15:8];
          win[5]   <= lb_rd_data[7:0];
          win[8]   <= grey;
          cur_mask <= mask_next;
          state    <= cur_emit ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          sx    <= sx_sum[10:0];
          sy    <= sy_sum[10:0];
          state <= ST_SQ;
        end
        ST_SQ: begin
          rt_v   <= ROOT_W'(sx_sq) + ROOT_W'(sy_sq);
          rt_res <= '0;
          rt_bit <= ROOT_FIRST_BIT;
          state  <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rt_v >= rt_trial) begin
            rt_v   <= rt_v - rt_trial;
            rt_res <= (rt_res >> 1) + rt_bit;
          end else begin
            rt_res <= rt_res >> 1;
          end
          rt_bit <= rt_bit >> 2;
          if (rt_bit[0]) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= {clamp_quarter(t_blue), clamp_quarter(t_green), clamp_quarter(t_red)};
            out_last  <= cur_last;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  // An accepted transaction always moves on to the window update.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_WIN))
    else $error("accepted transaction did not reach the window stage");

  // The square root unit works on exactly one result bit at a time.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> $onehot(rt_bit))
    else $error("square root step bit is not one-hot");

  // The last item of a frame always yields a result.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WIN && cur_last) |-> cur_emit)
    else $error("frame end item without a result");

  // A waiting result is never overwritten by the next one.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !m_axis_tready) |=> (state == ST_OUT))
    else $error("result loaded while the output register was full");

endmodule
